>>> design/rwhp_pkg.sv
// shared constants, types and command/status structs of the wav header parser
package rwhp_pkg;

  // field widths
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned HALF_W     = 16;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned SFMT_W     = 2;
  // bytes per sample is bits / 8, so three bits fewer
  localparam int unsigned BPS_W      = HALF_W - 3;
  localparam int unsigned BPF_W      = HALF_W + BPS_W;

  // fmt body bytes that are captured, the rest is skipped
  localparam logic [WORD_W-1:0] FMT_CAPTURE_BYTES = 32'd40;

  // chunk and header tags, first file byte in the low byte
  localparam logic [WORD_W-1:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [WORD_W-1:0] TAG_RF64 = 32'h3436_4652;
  localparam logic [WORD_W-1:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [WORD_W-1:0] TAG_FMT  = 32'h2074_6d66;
  localparam logic [WORD_W-1:0] TAG_DATA = 32'h6174_6164;

  // format tag and sample sizes that select the sample format
  localparam logic [HALF_W-1:0] AUDIO_FMT_FLOAT = 16'd3;
  localparam logic [HALF_W-1:0] SAMPLE_BITS_16  = 16'd16;
  localparam logic [HALF_W-1:0] SAMPLE_BITS_24  = 16'd24;

  // sample format codes
  localparam logic [SFMT_W-1:0] SFMT_FLOAT32 = 2'd0;
  localparam logic [SFMT_W-1:0] SFMT_PCM16   = 2'd1;
  localparam logic [SFMT_W-1:0] SFMT_PCM24   = 2'd2;
  localparam logic [SFMT_W-1:0] SFMT_PCM32   = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_RIFF  = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_WAVE  = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_NO_FMT    = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_TRUNCATED = 3'd4;

  // byte counter operations
  typedef enum logic [2:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_CLR,
    CNT_DEC,
    CNT_LEN,
    CNT_REM
  } cnt_op_t;

  // controller to datapath
  typedef struct packed {
    cnt_op_t               cnt_op;
    logic                  accept;
    logic                  tag_shift;
    logic                  len_shift;
    logic                  head_chk;
    logic                  fmt_clear;
    logic                  fmt_capture;
    logic                  fmt_seen_set;
    logic                  clear_all;
    logic                  data_capture;
    logic                  mul_go;
    logic                  div_go;
    logic                  res_fail;
    logic [STATUS_W-1:0]   res_status;
    logic                  res_ok;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cnt_eq3;
    logic cnt_eq11;
    logic cnt_lt4;
    logic cnt_lt7;
    logic cnt_le1;
    logic hdr_riff_bad;
    logic hdr_wave_ok;
    logic head_bad;
    logic tag_fmt;
    logic tag_data;
    logic len_nxt_zero;
    logic len_odd;
    logic fmt_last;
    logic fmt_rem_zero;
    logic fmt_seen;
    logic div_busy;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

>>> design/rwhp_intf.sv
// byte request channel and result request channel of the wav header parser

interface rwhp_byte_if;
  logic                           valid;
  logic                           ready;
  logic [rwhp_pkg::BYTE_W-1:0]    stream_byte;
  logic                           last_byte;

  modport source (output valid, output stream_byte, output last_byte, input ready);
  modport sink   (input valid, input stream_byte, input last_byte, output ready);
endinterface

interface rwhp_result_if;
  logic                           valid;
  logic                           ready;
  logic [rwhp_pkg::STATUS_W-1:0]  status;
  logic [rwhp_pkg::SFMT_W-1:0]    sample_format;
  logic [rwhp_pkg::HALF_W-1:0]    fmt_tag;
  logic [rwhp_pkg::HALF_W-1:0]    channel_count;
  logic [rwhp_pkg::WORD_W-1:0]    rate_hz;
  logic [rwhp_pkg::HALF_W-1:0]    sample_bits;
  logic [rwhp_pkg::WORD_W-1:0]    body_offset;
  logic [rwhp_pkg::WORD_W-1:0]    frame_count;

  modport source (output valid, output status, output sample_format, output fmt_tag,
                  output channel_count, output rate_hz, output sample_bits,
                  output body_offset, output frame_count, input ready);
  modport sink   (input valid, input status, input sample_format, input fmt_tag,
                  input channel_count, input rate_hz, input sample_bits,
                  input body_offset, input frame_count, output ready);
endinterface

>>> design/rwhp_div.sv
// radix-2 restoring divider, one quotient bit per cycle
module rwhp_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [rwhp_pkg::WORD_W-1:0]   dividend,
  input  logic [rwhp_pkg::BPF_W-1:0]    divisor,
  output logic                          busy,
  output logic                          done,
  output logic [rwhp_pkg::WORD_W-1:0]   quotient
);

  localparam int unsigned QW    = rwhp_pkg::WORD_W;
  localparam int unsigned DW    = rwhp_pkg::BPF_W;
  localparam int unsigned CNT_W = $clog2(QW);

  logic [QW-1:0]    quo_r, quo_nxt;
  logic [DW:0]      rem_r, rem_nxt;
  logic [DW-1:0]    dvs_r, dvs_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DW:0]      rem_sh;
  logic [DW+1:0]    diff;
  logic             ge;

  // trial subtract of the shifted remainder
  assign rem_sh = {rem_r[DW-1:0], quo_r[QW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs_r};
  assign ge     = ~diff[DW+1];

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = CNT_W'(QW - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DW:0] : rem_sh;
      quo_nxt = {quo_r[QW-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control resets, operands do not
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> design/rwhp_dp.sv
// parser datapath: byte counter, tag and length shifters, fmt fields, frame divide, result register
module rwhp_dp #(
  parameter logic [rwhp_pkg::WORD_W-1:0] FMT_CAP_BYTES = rwhp_pkg::FMT_CAPTURE_BYTES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rwhp_pkg::cmd_t                cmd,
  input  logic [rwhp_pkg::BYTE_W-1:0]   in_byte,
  output rwhp_pkg::sts_t                sts,
  rwhp_result_if.source                 out_chan
);

  localparam int unsigned W  = rwhp_pkg::WORD_W;
  localparam int unsigned HW = rwhp_pkg::HALF_W;

  // parse state
  logic [W-1:0]  cnt_r, cnt_nxt;
  logic [W-1:0]  tag_r, tag_nxt;
  logic [W-1:0]  len_r, len_nxt;
  logic [W-1:0]  pos_r, pos_nxt;
  logic [HW-1:0] ftag_r, ftag_nxt;
  logic [HW-1:0] chan_r, chan_nxt;
  logic [W-1:0]  rate_r, rate_nxt;
  logic [HW-1:0] bits_r, bits_nxt;
  logic          fmt_seen_r, fmt_seen_nxt;
  logic          head_bad_r, head_bad_nxt;

  // held result fields while the frame count is worked out
  logic [HW-1:0]                 h_ftag_r;
  logic [HW-1:0]                 h_chan_r;
  logic [W-1:0]                  h_rate_r;
  logic [HW-1:0]                 h_bits_r;
  logic [rwhp_pkg::SFMT_W-1:0]   h_sfmt_r;
  logic [W-1:0]                  h_off_r;
  logic [W-1:0]                  dvd_r;
  logic [rwhp_pkg::BPF_W-1:0]    bpf_r;

  // result register
  logic                            out_valid_r, out_valid_nxt;
  logic [rwhp_pkg::STATUS_W-1:0]   o_status_r;
  logic [rwhp_pkg::SFMT_W-1:0]     o_sfmt_r;
  logic [HW-1:0]                   o_ftag_r;
  logic [HW-1:0]                   o_chan_r;
  logic [W-1:0]                    o_rate_r;
  logic [HW-1:0]                   o_bits_r;
  logic [W-1:0]                    o_off_r;
  logic [W-1:0]                    o_frames_r;

  logic [W-1:0]                  tag_sh, len_sh, cap, pos_inc;
  logic [rwhp_pkg::SFMT_W-1:0]   sfmt;
  logic                          div_busy, div_done;
  logic [W-1:0]                  quotient;

  assign tag_sh  = {in_byte, tag_r[W-1:8]};
  assign len_sh  = {in_byte, len_r[W-1:8]};
  assign cap     = (len_r < FMT_CAP_BYTES) ? len_r : FMT_CAP_BYTES;
  assign pos_inc = (pos_r == '1) ? pos_r : pos_r + 1'b1;

  // sample format from the captured fmt fields
  always_comb begin
    priority if (ftag_r == rwhp_pkg::AUDIO_FMT_FLOAT) sfmt = rwhp_pkg::SFMT_FLOAT32;
    else if (bits_r == rwhp_pkg::SAMPLE_BITS_16)      sfmt = rwhp_pkg::SFMT_PCM16;
    else if (bits_r == rwhp_pkg::SAMPLE_BITS_24)      sfmt = rwhp_pkg::SFMT_PCM24;
    else                                              sfmt = rwhp_pkg::SFMT_PCM32;
  end

  // status to the controller
  always_comb begin
    sts.cnt_eq3      = (cnt_r == 32'd3);
    sts.cnt_eq11     = (cnt_r == 32'd11);
    sts.cnt_lt4      = (cnt_r < 32'd4);
    sts.cnt_lt7      = (cnt_r < 32'd7);
    sts.cnt_le1      = (cnt_r <= 32'd1);
    sts.hdr_riff_bad = (tag_sh != rwhp_pkg::TAG_RIFF) && (tag_sh != rwhp_pkg::TAG_RF64);
    sts.hdr_wave_ok  = (tag_sh == rwhp_pkg::TAG_WAVE);
    sts.head_bad     = head_bad_r;
    sts.tag_fmt      = (tag_r == rwhp_pkg::TAG_FMT);
    sts.tag_data     = (tag_r == rwhp_pkg::TAG_DATA);
    sts.len_nxt_zero = (len_sh == '0);
    sts.len_odd      = len_r[0];
    sts.fmt_last     = (cnt_r >= cap - 1'b1);
    sts.fmt_rem_zero = (len_r <= FMT_CAP_BYTES);
    sts.fmt_seen     = fmt_seen_r;
    sts.div_busy     = div_busy;
    sts.div_done     = div_done;
    sts.out_free     = ~out_valid_r | out_chan.ready;
  end

  // next values of the parse state, a full clear on the final byte wins
  always_comb begin
    cnt_nxt      = cnt_r;
    tag_nxt      = tag_r;
    len_nxt      = len_r;
    pos_nxt      = pos_r;
    ftag_nxt     = ftag_r;
    chan_nxt     = chan_r;
    rate_nxt     = rate_r;
    bits_nxt     = bits_r;
    fmt_seen_nxt = fmt_seen_r;
    head_bad_nxt = head_bad_r;
    if (cmd.clear_all) begin
      cnt_nxt      = '0;
      tag_nxt      = '0;
      len_nxt      = '0;
      pos_nxt      = '0;
      ftag_nxt     = '0;
      chan_nxt     = '0;
      rate_nxt     = '0;
      bits_nxt     = '0;
      fmt_seen_nxt = 1'b0;
      head_bad_nxt = 1'b0;
    end else begin
      if (cmd.accept)    pos_nxt = pos_inc;
      if (cmd.tag_shift) tag_nxt = tag_sh;
      if (cmd.len_shift) len_nxt = len_sh;
      if (cmd.head_chk)  head_bad_nxt = sts.hdr_riff_bad;
      if (cmd.fmt_seen_set) fmt_seen_nxt = 1'b1;
      unique case (cmd.cnt_op)
        rwhp_pkg::CNT_HOLD: cnt_nxt = cnt_r;
        rwhp_pkg::CNT_INC:  cnt_nxt = cnt_r + 1'b1;
        rwhp_pkg::CNT_CLR:  cnt_nxt = '0;
        rwhp_pkg::CNT_DEC:  cnt_nxt = (cnt_r != '0) ? cnt_r - 1'b1 : cnt_r;
        rwhp_pkg::CNT_LEN:  cnt_nxt = len_sh;
        rwhp_pkg::CNT_REM:  cnt_nxt = len_r - cap;
        default:            cnt_nxt = cnt_r;
      endcase
      // a new fmt chunk starts from zeroed fields
      if (cmd.fmt_clear) begin
        ftag_nxt = '0;
        chan_nxt = '0;
        rate_nxt = '0;
        bits_nxt = '0;
      end
      // place the byte by its offset in the fmt body
      if (cmd.fmt_capture) begin
        if (cnt_r == 32'd0)  ftag_nxt[7:0]   = in_byte;
        if (cnt_r == 32'd1)  ftag_nxt[15:8]  = in_byte;
        if (cnt_r == 32'd2)  chan_nxt[7:0]   = in_byte;
        if (cnt_r == 32'd3)  chan_nxt[15:8]  = in_byte;
        if (cnt_r == 32'd4)  rate_nxt[7:0]   = in_byte;
        if (cnt_r == 32'd5)  rate_nxt[15:8]  = in_byte;
        if (cnt_r == 32'd6)  rate_nxt[23:16] = in_byte;
        if (cnt_r == 32'd7)  rate_nxt[31:24] = in_byte;
        if (cnt_r == 32'd14) bits_nxt[7:0]   = in_byte;
        if (cnt_r == 32'd15) bits_nxt[15:8]  = in_byte;
      end
    end
  end

  // result register next valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_chan.ready) out_valid_nxt = 1'b0;
    if (cmd.res_fail || cmd.res_ok) out_valid_nxt = 1'b1;
  end

  // frame count divider
  rwhp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_go),
    .dividend (dvd_r),
    .divisor  (bpf_r),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quotient)
  );

  // parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      tag_r       <= '0;
      len_r       <= '0;
      pos_r       <= '0;
      ftag_r      <= '0;
      chan_r      <= '0;
      rate_r      <= '0;
      bits_r      <= '0;
      fmt_seen_r  <= 1'b0;
      head_bad_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      tag_r       <= tag_nxt;
      len_r       <= len_nxt;
      pos_r       <= pos_nxt;
      ftag_r      <= ftag_nxt;
      chan_r      <= chan_nxt;
      rate_r      <= rate_nxt;
      bits_r      <= bits_nxt;
      fmt_seen_r  <= fmt_seen_nxt;
      head_bad_r  <= head_bad_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // hold fields of a good data header and the bytes per frame product
  always_ff @(posedge clk) begin
    if (cmd.data_capture) begin
      h_ftag_r <= ftag_r;
      h_chan_r <= chan_r;
      h_rate_r <= rate_r;
      h_bits_r <= bits_r;
      h_sfmt_r <= sfmt;
      h_off_r  <= pos_inc;
      dvd_r    <= len_sh;
    end
    if (cmd.mul_go) begin
      bpf_r <= h_chan_r * h_bits_r[HW-1:3];
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.res_fail) begin
      o_status_r <= cmd.res_status;
      o_sfmt_r   <= '0;
      o_ftag_r   <= '0;
      o_chan_r   <= '0;
      o_rate_r   <= '0;
      o_bits_r   <= '0;
      o_off_r    <= '0;
      o_frames_r <= '0;
    end else if (cmd.res_ok) begin
      o_status_r <= rwhp_pkg::STATUS_OK;
      o_sfmt_r   <= h_sfmt_r;
      o_ftag_r   <= h_ftag_r;
      o_chan_r   <= h_chan_r;
      o_rate_r   <= h_rate_r;
      o_bits_r   <= h_bits_r;
      o_off_r    <= h_off_r;
      o_frames_r <= (bpf_r == '0) ? '0 : quotient;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.status        = o_status_r;
  assign out_chan.sample_format = o_sfmt_r;
  assign out_chan.fmt_tag       = o_ftag_r;
  assign out_chan.channel_count = o_chan_r;
  assign out_chan.rate_hz       = o_rate_r;
  assign out_chan.sample_bits   = o_bits_r;
  assign out_chan.body_offset   = o_off_r;
  assign out_chan.frame_count   = o_frames_r;

endmodule

>>> design/rwhp_ctrl.sv
// parser controller: header and chunk walk, fmt capture, skipping, frame divide sequencing
module rwhp_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_last,
  output logic                  in_ready,
  input  rwhp_pkg::sts_t        sts,
  output rwhp_pkg::cmd_t        cmd
);

  typedef enum logic [3:0] {
    PH_HEADER,
    PH_CHUNK,
    PH_FMT,
    PH_SKIP_PAD,
    PH_SKIP,
    PH_PAD,
    PH_DONE,
    PH_MUL,
    PH_DIVGO,
    PH_DIV
  } phase_t;

  phase_t phase_r, phase_nxt;
  logic   last_pend_r, last_pend_nxt;
  logic   acc;
  logic   emitted;
  logic   data_ok;
  logic   parsing;

  // bytes are taken while parsing; a result may only wait if no new one can arise
  always_comb begin
    parsing  = (phase_r != PH_MUL) && (phase_r != PH_DIVGO) && (phase_r != PH_DIV);
    in_ready = parsing && (sts.out_free || (phase_r == PH_DONE));
    acc      = in_valid && in_ready;
  end

  always_comb begin
    cmd            = '0;
    cmd.cnt_op     = rwhp_pkg::CNT_HOLD;
    cmd.accept     = acc;
    phase_nxt      = phase_r;
    last_pend_nxt  = last_pend_r;
    emitted        = 1'b0;
    data_ok        = 1'b0;

    unique case (phase_r)
      // file header: riff tag, size, wave tag
      PH_HEADER: begin
        if (acc) begin
          cmd.tag_shift = 1'b1;
          cmd.head_chk  = sts.cnt_eq3;
          if (sts.cnt_eq11) begin
            cmd.cnt_op = rwhp_pkg::CNT_CLR;
            if (sts.head_bad) begin
              cmd.res_fail   = 1'b1;
              cmd.res_status = rwhp_pkg::STATUS_NOT_RIFF;
              emitted        = 1'b1;
              phase_nxt      = PH_DONE;
            end else if (!sts.hdr_wave_ok) begin
              cmd.res_fail   = 1'b1;
              cmd.res_status = rwhp_pkg::STATUS_NOT_WAVE;
              emitted        = 1'b1;
              phase_nxt      = PH_DONE;
            end else begin
              phase_nxt = PH_CHUNK;
            end
          end else begin
            cmd.cnt_op = rwhp_pkg::CNT_INC;
          end
        end
      end

      // chunk header: tag then length, decided on its eighth byte
      PH_CHUNK: begin
        if (acc) begin
          cmd.tag_shift = sts.cnt_lt4;
          cmd.len_shift = !sts.cnt_lt4;
          if (sts.cnt_lt7) begin
            cmd.cnt_op = rwhp_pkg::CNT_INC;
          end else if (sts.tag_fmt) begin
            cmd.fmt_clear = 1'b1;
            cmd.cnt_op    = rwhp_pkg::CNT_CLR;
            if (sts.len_nxt_zero) begin
              cmd.fmt_seen_set = 1'b1;
              phase_nxt        = PH_CHUNK;
            end else begin
              phase_nxt = PH_FMT;
            end
          end else if (sts.tag_data) begin
            cmd.cnt_op = rwhp_pkg::CNT_CLR;
            emitted    = 1'b1;
            if (!sts.fmt_seen) begin
              cmd.res_fail   = 1'b1;
              cmd.res_status = rwhp_pkg::STATUS_NO_FMT;
              phase_nxt      = PH_DONE;
            end else begin
              cmd.data_capture = 1'b1;
              data_ok          = 1'b1;
              phase_nxt        = PH_MUL;
            end
          end else begin
            cmd.cnt_op = rwhp_pkg::CNT_LEN;
            phase_nxt  = sts.len_nxt_zero ? PH_CHUNK : PH_SKIP_PAD;
          end
        end
      end

      // fmt body capture, any remainder is skipped without padding
      PH_FMT: begin
        if (acc) begin
          cmd.fmt_capture = 1'b1;
          if (sts.fmt_last) begin
            cmd.fmt_seen_set = 1'b1;
            cmd.cnt_op       = rwhp_pkg::CNT_REM;
            phase_nxt        = sts.fmt_rem_zero ? PH_CHUNK : PH_SKIP;
          end else begin
            cmd.cnt_op = rwhp_pkg::CNT_INC;
          end
        end
      end

      // skip an unknown chunk, then its pad byte on an odd size
      PH_SKIP_PAD: begin
        if (acc) begin
          cmd.cnt_op = rwhp_pkg::CNT_DEC;
          if (sts.cnt_le1) phase_nxt = sts.len_odd ? PH_PAD : PH_CHUNK;
        end
      end

      // skip the tail of a long fmt chunk
      PH_SKIP: begin
        if (acc) begin
          cmd.cnt_op = rwhp_pkg::CNT_DEC;
          if (sts.cnt_le1) phase_nxt = PH_CHUNK;
        end
      end

      PH_PAD: begin
        if (acc) phase_nxt = PH_CHUNK;
      end

      // result given, bytes ignored up to the end of the file
      PH_DONE: begin
        phase_nxt = PH_DONE;
      end

      // bytes per frame product
      PH_MUL: begin
        cmd.mul_go = 1'b1;
        phase_nxt  = PH_DIVGO;
      end

      PH_DIVGO: begin
        cmd.div_go = 1'b1;
        phase_nxt  = PH_DIV;
      end

      PH_DIV: begin
        if (sts.div_done) begin
          cmd.res_ok = 1'b1;
          phase_nxt  = last_pend_r ? PH_HEADER : PH_DONE;
        end
      end

      default: phase_nxt = PH_HEADER;
    endcase

    // end of file: truncated if nothing was reported, then start over
    if (acc) begin
      last_pend_nxt = 1'b0;
      if (in_last) begin
        if (!emitted && (phase_r != PH_DONE)) begin
          cmd.res_fail   = 1'b1;
          cmd.res_status = rwhp_pkg::STATUS_TRUNCATED;
        end
        cmd.clear_all = 1'b1;
        last_pend_nxt = data_ok;
        phase_nxt     = data_ok ? PH_MUL : PH_HEADER;
      end
    end
  end

  // phase and pending-last registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      last_pend_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      last_pend_r <= last_pend_nxt;
    end
  end

endmodule

>>> design/riff_wave_header_parser.sv
// Byte-stream wav header parser: one file byte per request, one result per file.
// Throughput: one byte per cycle while the result register is free or being read; the data
// chunk header stalls input for the multiply step, the divider load and the bit-serial
// frame-count divide. Results: a failure result is registered at the edge that takes the
// deciding byte; a good result is registered when the frame-count divide is done.
// Reset: synchronous, active low; parser returns to the file header, result register empties.
module riff_wave_header_parser #(
  parameter logic [rwhp_pkg::WORD_W-1:0] FMT_CAP_BYTES = rwhp_pkg::FMT_CAPTURE_BYTES
) (
  input  logic            clk,
  input  logic            rst_n,
  rwhp_byte_if.sink       in_chan,
  rwhp_result_if.source   out_chan
);

  rwhp_pkg::cmd_t cmd;
  rwhp_pkg::sts_t sts;
  logic           in_ready;

  // controller
  rwhp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_last  (in_chan.last_byte),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  rwhp_dp #(
    .FMT_CAP_BYTES (FMT_CAP_BYTES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_byte  (in_chan.stream_byte),
    .sts      (sts),
    .out_chan (out_chan)
  );

  assign in_chan.ready = in_ready;

  // no request is taken while the frame count is being divided
  a_no_take_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |-> !sts.div_busy)
    else $error("request taken while divider busy");

  // a finished divide always finds the result register empty
  a_out_free_at_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> !out_chan.valid)
    else $error("result register occupied at divide completion");

  // the input is held off after the multiply step
  a_stall_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_go |=> !in_chan.ready)
    else $error("input ready during frame count sequence");

endmodule

>>> test/testbench.sv
// self-checking testbench of the riff wave header parser: byte stream in, one result per file
module testbench;

  // one parsed header as it leaves the block
  typedef struct packed {
    logic [rwhp_pkg::STATUS_W-1:0] status;
    logic [rwhp_pkg::SFMT_W-1:0]   sample_format;
    logic [rwhp_pkg::HALF_W-1:0]   fmt_tag;
    logic [rwhp_pkg::HALF_W-1:0]   channel_count;
    logic [rwhp_pkg::WORD_W-1:0]   rate_hz;
    logic [rwhp_pkg::HALF_W-1:0]   sample_bits;
    logic [rwhp_pkg::WORD_W-1:0]   body_offset;
    logic [rwhp_pkg::WORD_W-1:0]   frame_count;
  } wav_header_t;

  // where the parser stands in the file
  typedef enum logic [2:0] {
    WALK_HEADER,
    WALK_CHUNK,
    WALK_FMT,
    WALK_SKIP_PAD,
    WALK_SKIP,
    WALK_PAD,
    WALK_DONE
  } walk_state_t;

  // own copy of the parser, predicts the header of every file and checks it
  class wav_header_checker;
    walk_state_t                 walk;
    logic [rwhp_pkg::WORD_W-1:0] byte_count;
    logic [rwhp_pkg::WORD_W-1:0] chunk_tag;
    logic [rwhp_pkg::WORD_W-1:0] chunk_len;
    logic [rwhp_pkg::WORD_W-1:0] position;
    logic [rwhp_pkg::HALF_W-1:0] fmt_code;
    logic [rwhp_pkg::HALF_W-1:0] fmt_channels;
    logic [rwhp_pkg::WORD_W-1:0] fmt_rate;
    logic [rwhp_pkg::HALF_W-1:0] fmt_bits;
    bit                          fmt_seen;
    bit                          header_sent;
    bit                          riff_bad;
    wav_header_t                 expected_headers[$];
    int                          mismatches;

    function new();
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      walk         = WALK_HEADER;
      byte_count   = '0;
      chunk_tag    = '0;
      chunk_len    = '0;
      position     = '0;
      fmt_code     = '0;
      fmt_channels = '0;
      fmt_rate     = '0;
      fmt_bits     = '0;
      fmt_seen     = 1'b0;
      header_sent  = 1'b0;
      riff_bad     = 1'b0;
    endfunction

    function logic [rwhp_pkg::WORD_W-1:0] captured_len();
      return (chunk_len < rwhp_pkg::FMT_CAPTURE_BYTES) ? chunk_len
             : rwhp_pkg::FMT_CAPTURE_BYTES;
    endfunction

    // queue the result of this file, failures carry only the status
    function void finish_file(logic [rwhp_pkg::STATUS_W-1:0] status,
                              logic [rwhp_pkg::WORD_W-1:0] frames);
      wav_header_t hdr;
      hdr = '0;
      hdr.status = status;
      if (status == rwhp_pkg::STATUS_OK) begin
        if (fmt_code == rwhp_pkg::AUDIO_FMT_FLOAT) hdr.sample_format = rwhp_pkg::SFMT_FLOAT32;
        else if (fmt_bits == rwhp_pkg::SAMPLE_BITS_16) hdr.sample_format = rwhp_pkg::SFMT_PCM16;
        else if (fmt_bits == rwhp_pkg::SAMPLE_BITS_24) hdr.sample_format = rwhp_pkg::SFMT_PCM24;
        else hdr.sample_format = rwhp_pkg::SFMT_PCM32;
        hdr.fmt_tag       = fmt_code;
        hdr.channel_count = fmt_channels;
        hdr.rate_hz       = fmt_rate;
        hdr.sample_bits   = fmt_bits;
        hdr.body_offset   = position;
        hdr.frame_count   = frames;
      end
      expected_headers.push_back(hdr);
      header_sent = 1'b1;
      walk = WALK_DONE;
    endfunction

    // rest of an extended fmt body is skipped without padding
    function void fmt_finish();
      fmt_seen = 1'b1;
      byte_count = chunk_len - captured_len();
      walk = (byte_count != 0) ? WALK_SKIP : WALK_CHUNK;
    endfunction

    function void skip_finish();
      walk = (walk == WALK_SKIP_PAD && chunk_len[0]) ? WALK_PAD : WALK_CHUNK;
    endfunction

    // advance the parser by one accepted byte request
    function void note_byte(logic [7:0] value, logic last);
      logic [rwhp_pkg::WORD_W-1:0] offs;
      logic [rwhp_pkg::WORD_W-1:0] frame_bytes;
      if (position != '1) position++;
      case (walk)
        WALK_HEADER: begin
          chunk_tag = {value, chunk_tag[rwhp_pkg::WORD_W-1:8]};
          if (byte_count == 3)
            riff_bad = (chunk_tag != rwhp_pkg::TAG_RIFF) && (chunk_tag != rwhp_pkg::TAG_RF64);
          if (byte_count == 11) begin
            byte_count = '0;
            if (riff_bad) finish_file(rwhp_pkg::STATUS_NOT_RIFF, '0);
            else if (chunk_tag != rwhp_pkg::TAG_WAVE) finish_file(rwhp_pkg::STATUS_NOT_WAVE, '0);
            else walk = WALK_CHUNK;
          end else begin
            byte_count++;
          end
        end
        WALK_CHUNK: begin
          if (byte_count < 4) chunk_tag = {value, chunk_tag[rwhp_pkg::WORD_W-1:8]};
          else chunk_len = {value, chunk_len[rwhp_pkg::WORD_W-1:8]};
          if (byte_count < 7) begin
            byte_count++;
          end else begin
            byte_count = '0;
            if (chunk_tag == rwhp_pkg::TAG_FMT) begin
              // a later fmt chunk replaces the earlier one
              fmt_code     = '0;
              fmt_channels = '0;
              fmt_rate     = '0;
              fmt_bits     = '0;
              if (chunk_len == 0) fmt_finish();
              else walk = WALK_FMT;
            end else if (chunk_tag == rwhp_pkg::TAG_DATA) begin
              if (!fmt_seen) begin
                finish_file(rwhp_pkg::STATUS_NO_FMT, '0);
              end else begin
                frame_bytes = 32'(fmt_channels) * 32'(fmt_bits >> 3);
                finish_file(rwhp_pkg::STATUS_OK,
                            (frame_bytes != 0) ? chunk_len / frame_bytes : '0);
              end
            end else begin
              byte_count = chunk_len;
              walk = WALK_SKIP_PAD;
              if (chunk_len == 0) skip_finish();
            end
          end
        end
        WALK_FMT: begin
          offs = byte_count;
          if (offs < 2) fmt_code[8*offs +: 8] = value;
          else if (offs < 4) fmt_channels[8*(offs-2) +: 8] = value;
          else if (offs < 8) fmt_rate[8*(offs-4) +: 8] = value;
          else if (offs == 14 || offs == 15) fmt_bits[8*(offs-14) +: 8] = value;
          byte_count = offs + 1;
          if (byte_count >= captured_len()) fmt_finish();
        end
        WALK_SKIP_PAD, WALK_SKIP: begin
          if (byte_count != 0) byte_count--;
          if (byte_count == 0) skip_finish();
        end
        WALK_PAD: begin
          walk = WALK_CHUNK;
        end
        default: begin
        end
      endcase
      // end of file: truncated unless a result already went out
      if (last) begin
        if (!header_sent) finish_file(rwhp_pkg::STATUS_TRUNCATED, '0);
        restart();
      end
    endfunction

    task report(string what);
      mismatches++;
      $display("%0t: mismatch: %s", $time, what);
    endtask

    task compare(string field, logic [rwhp_pkg::WORD_W-1:0] got,
                 logic [rwhp_pkg::WORD_W-1:0] want);
      if (got !== want) report($sformatf("%s got %0h want %0h", field, got, want));
    endtask

    // compare one result request with the oldest expected header
    task check_result(wav_header_t got);
      wav_header_t want;
      if (expected_headers.size() == 0) begin
        report("header result with no file pending");
        return;
      end
      want = expected_headers.pop_front();
      compare("status", 32'(got.status), 32'(want.status));
      compare("sample_format", 32'(got.sample_format), 32'(want.sample_format));
      compare("fmt_tag", 32'(got.fmt_tag), 32'(want.fmt_tag));
      compare("channel_count", 32'(got.channel_count), 32'(want.channel_count));
      compare("rate_hz", got.rate_hz, want.rate_hz);
      compare("sample_bits", 32'(got.sample_bits), 32'(want.sample_bits));
      compare("body_offset", got.body_offset, want.body_offset);
      compare("frame_count", got.frame_count, want.frame_count);
    endtask
  endclass

  logic clk;
  logic rst_n;

  rwhp_byte_if   byte_chan ();
  rwhp_result_if result_chan ();

  riff_wave_header_parser dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (byte_chan),
    .out_chan (result_chan)
  );

  wav_header_checker headers;
  logic [7:0]        wav_bytes[$];
  int                burst_left;
  int                bytes_sent;
  bit                hold_results_req;

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // watch both channels at the rising edge
  always @(posedge clk) begin : channel_monitor
    wav_header_t seen;
    if (rst_n) begin
      if (byte_chan.valid && byte_chan.ready)
        headers.note_byte(byte_chan.stream_byte, byte_chan.last_byte);
      if (result_chan.valid && result_chan.ready) begin
        seen.status        = result_chan.status;
        seen.sample_format = result_chan.sample_format;
        seen.fmt_tag       = result_chan.fmt_tag;
        seen.channel_count = result_chan.channel_count;
        seen.rate_hz       = result_chan.rate_hz;
        seen.sample_bits   = result_chan.sample_bits;
        seen.body_offset   = result_chan.body_offset;
        seen.frame_count   = result_chan.frame_count;
        headers.check_result(seen);
      end
    end
  end

  // result receiver: changing stall patterns, plus one long hold-off on request
  initial begin : result_receiver
    int mode;
    int span;
    int tick;
    int stall_left;
    tick = 0;
    stall_left = 0;
    result_chan.ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 4);
      span = $urandom_range(16, 160);
      repeat (span) begin
        @(negedge clk);
        tick++;
        if (hold_results_req) begin
          hold_results_req = 1'b0;
          stall_left = 400;
        end
        if (stall_left > 0) begin
          stall_left--;
          result_chan.ready <= 1'b0;
        end else begin
          case (mode)
            0, 1: result_chan.ready <= 1'b1;
            2: result_chan.ready <= 1'($urandom_range(0, 1));
            3: result_chan.ready <= (tick % 4) != 3;
            default: result_chan.ready <= (tick % 7) < 2;
          endcase
        end
      end
    end
  end

  // file building helpers, multi-byte values go out low byte first
  function automatic void put_u32(logic [31:0] v);
    for (int i = 0; i < 4; i++) wav_bytes.push_back(v[8*i +: 8]);
  endfunction

  function automatic void put_riff_wave();
    put_u32($urandom_range(0, 1) ? rwhp_pkg::TAG_RIFF : rwhp_pkg::TAG_RF64);
    put_u32($urandom);
    put_u32(rwhp_pkg::TAG_WAVE);
  endfunction

  // fmt chunk: mostly canonical, sometimes short or extended
  function automatic void put_fmt_chunk();
    logic [31:0]  len;
    logic [15:0]  code;
    logic [15:0]  chans;
    logic [31:0]  rate;
    logic [15:0]  nbits;
    logic [127:0] fields;
    int           pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) len = 16;
    else if (pick == 5) len = 18;
    else if (pick == 6) len = 40;
    else if (pick == 7) len = $urandom_range(41, 50);
    else if (pick == 8) len = $urandom_range(0, 15);
    else len = $urandom_range(17, 39);
    pick = $urandom_range(0, 9);
    code = (pick < 4) ? 16'd1 : (pick < 6) ? rwhp_pkg::AUDIO_FMT_FLOAT
         : (pick == 6) ? 16'hFFFE : 16'($urandom);
    pick = $urandom_range(0, 9);
    chans = (pick < 6) ? 16'($urandom_range(1, 8)) : (pick == 6) ? 16'd0
          : (pick == 7) ? 16'hFFFF : 16'($urandom);
    rate = $urandom_range(0, 1) ? 32'd48000 : 32'($urandom);
    pick = $urandom_range(0, 9);
    nbits = (pick < 2) ? rwhp_pkg::SAMPLE_BITS_16 : (pick < 4) ? rwhp_pkg::SAMPLE_BITS_24
          : (pick < 6) ? 16'd32 : (pick == 6) ? 16'd8 : (pick == 7) ? 16'd0
          : 16'($urandom);
    fields = {nbits, 16'($urandom), 32'($urandom), rate, chans, code};
    put_u32(rwhp_pkg::TAG_FMT);
    put_u32(len);
    for (int i = 0; i < len; i++)
      wav_bytes.push_back((i < 16) ? fields[8*i +: 8] : 8'($urandom));
  endfunction

  // unknown chunk with a short body, padded to even size
  function automatic void put_other_chunk();
    logic [31:0] tag;
    int          len;
    tag = $urandom;
    while (tag == rwhp_pkg::TAG_FMT || tag == rwhp_pkg::TAG_DATA) tag = $urandom;
    len = $urandom_range(0, 7);
    put_u32(tag);
    put_u32(32'(len));
    repeat (len) wav_bytes.push_back(8'($urandom));
    if (len % 2) wav_bytes.push_back(8'($urandom));
  endfunction

  // well-formed file with random content
  function automatic void build_wav_file();
    int lead_chunks;
    int fmt_slot;
    int pick;
    wav_bytes.delete();
    put_riff_wave();
    lead_chunks = $urandom_range(0, 2);
    fmt_slot = $urandom_range(0, lead_chunks);
    for (int i = 0; i <= lead_chunks; i++) begin
      if (i == fmt_slot) put_fmt_chunk();
      else put_other_chunk();
    end
    if ($urandom_range(0, 5) == 0) put_fmt_chunk();
    put_u32(rwhp_pkg::TAG_DATA);
    pick = $urandom_range(0, 5);
    put_u32((pick == 0) ? 32'd0 : (pick == 1) ? 32'hFFFF_FFFF
          : (pick == 2) ? 32'($urandom_range(0, 4096)) : 32'($urandom));
    repeat ($urandom_range(0, 3)) wav_bytes.push_back(8'($urandom));
  endfunction

  // one byte request, sender works in bursts with random gaps
  task automatic send_byte(input logic [7:0] value, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        byte_chan.valid <= 1'b0;
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 20);
    end
    @(negedge clk);
    byte_chan.valid       <= 1'b1;
    byte_chan.stream_byte <= value;
    byte_chan.last_byte   <= last;
    @(posedge clk);
    while (!byte_chan.ready) @(posedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_file();
    for (int i = 0; i < wav_bytes.size(); i++)
      send_byte(wav_bytes[i], i == wav_bytes.size() - 1);
  endtask

  // run limit
  initial begin
    #5000000;
    $display("riff_wave_header_parser test failed");
    $finish;
  end

  // stimulus and end of run
  initial begin : stimulus
    int files;
    int pick;
    int cut;
    headers = new();
    burst_left = 0;
    bytes_sent = 0;
    hold_results_req = 1'b0;
    rst_n = 1'b0;
    byte_chan.valid = 1'b0;
    byte_chan.stream_byte = '0;
    byte_chan.last_byte = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // bad riff tag with all-ones and all-zero bytes, wave tag fine
    wav_bytes.delete();
    put_u32(32'hFFFF_FFFF);
    put_u32(32'h0000_0000);
    put_u32(rwhp_pkg::TAG_WAVE);
    send_file();
    // rf64 accepted, wave tag wrong
    wav_bytes.delete();
    put_u32(rwhp_pkg::TAG_RF64);
    put_u32(32'h0);
    put_u32(~rwhp_pkg::TAG_WAVE);
    send_file();
    // file ending on its first byte
    wav_bytes.delete();
    wav_bytes.push_back(8'hFF);
    send_file();
    // data chunk before any fmt, file ends on the data header
    wav_bytes.delete();
    put_u32(rwhp_pkg::TAG_RIFF);
    put_u32(32'h0);
    put_u32(rwhp_pkg::TAG_WAVE);
    put_u32(rwhp_pkg::TAG_DATA);
    put_u32(32'h10);
    send_file();
    // empty fmt, odd unknown chunk with pad, largest data size, trailing bytes ignored
    wav_bytes.delete();
    put_u32(rwhp_pkg::TAG_RIFF);
    put_u32(32'hFFFF_FFFF);
    put_u32(rwhp_pkg::TAG_WAVE);
    put_u32(rwhp_pkg::TAG_FMT);
    put_u32(32'h0);
    put_u32(32'h4B4E_554A);
    put_u32(32'h1);
    wav_bytes.push_back(8'hA5);
    wav_bytes.push_back(8'h00);
    put_u32(rwhp_pkg::TAG_DATA);
    put_u32(32'hFFFF_FFFF);
    wav_bytes.push_back(8'h5A);
    wav_bytes.push_back(8'hFF);
    send_file();

    // random files: mostly well formed, some cut short, corrupted or pure noise
    files = 0;
    while (bytes_sent < 1650) begin
      if (files == 6) begin
        // receiver holds off while short files keep coming
        hold_results_req = 1'b1;
        repeat (5) begin
          wav_bytes.delete();
          repeat (12) wav_bytes.push_back(8'($urandom));
          send_file();
        end
      end
      pick = $urandom_range(0, 99);
      build_wav_file();
      if (pick >= 70 && pick < 82) begin
        cut = $urandom_range(1, wav_bytes.size());
        while (wav_bytes.size() > cut) void'(wav_bytes.pop_back());
      end else if (pick >= 82 && pick < 94) begin
        wav_bytes[$urandom_range(0, wav_bytes.size() - 1)] = 8'($urandom);
      end else if (pick >= 94) begin
        wav_bytes.delete();
        repeat ($urandom_range(1, 40)) wav_bytes.push_back(8'($urandom));
      end
      send_file();
      files++;
    end
    @(negedge clk);
    byte_chan.valid <= 1'b0;

    // drain, then allow for the frame-count divider
    while (headers.expected_headers.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (headers.mismatches == 0 && headers.expected_headers.size() == 0) begin
      $display("riff_wave_header_parser test passed");
    end else begin
      $display("riff_wave_header_parser test failed");
    end
    $finish;
  end

endmodule
